// ----- hw/rtl/dbnd_pkg.sv -----
// shared types and constants of the delta bit-packed neighbor decoder
package dbnd_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned IdW    = 32;
  localparam int unsigned DegW   = 7;
  localparam int unsigned WidthW = 6;
  localparam int unsigned BufW   = 40;
  localparam int unsigned BitsW  = 6;
  localparam int unsigned HdrW   = 3;

  localparam logic [WidthW-1:0] MaxDeltaWidth = 6'd32;
  localparam logic [HdrW-1:0]   LastHdrByte   = 3'd3;
  localparam logic [BitsW-1:0]  BitsPerByte   = 6'd8;

  typedef struct packed {
    logic take;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic can_emit;
  } dp_status_t;

endpackage

// ----- hw/rtl/dbnd_if.sv -----
// stream channel interfaces for compressed bytes and decoded neighbor ids
interface dbnd_in_if;
  logic                          valid;
  logic                          ready;
  logic [dbnd_pkg::ByteW-1:0]    data_byte;
  logic                          list_start;
  logic [dbnd_pkg::DegW-1:0]     degree;

  modport source (output valid, output data_byte, output list_start, output degree,
                  input ready);
  modport sink   (input valid, input data_byte, input list_start, input degree,
                  output ready);
endinterface

interface dbnd_out_if;
  logic                        valid;
  logic                        ready;
  logic [dbnd_pkg::IdW-1:0]    neighbor_id;
  logic                        last;

  modport source (output valid, output neighbor_id, output last, input ready);
  modport sink   (input valid, input neighbor_id, input last, output ready);
endinterface

// ----- hw/rtl/delta_bitpack_neighbor_decoder.sv -----
// top level of the delta bit-packed neighbor list decoder
//
// in_i carries the compressed list one byte per transfer: a width header
// byte flagged by list_start together with the list degree, four
// little-endian bytes of the first id, then packed deltas, LSB first.
// out_o delivers the ascending neighbor ids; last marks the final id of a list.
// a header byte always restarts decoding; bytes outside a list are dropped.
// sequence: each input transfer is followed by an evaluation state in
// which the datapath looks for a complete id. each id found is loaded
// into the output register, transferred, and then followed by another
// evaluation; a byte ends its work when no complete id is left. the
// output register and the controller sequence keep one byte or one id
// in work at a time, so in_i is never ready while an id is pending.
// while the receiver holds ready low the id stays on out_o and in_i is
// not ready. after reset the block is idle and ready for a header byte.
module delta_bitpack_neighbor_decoder #(
  parameter int unsigned MAX_DEGREE = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  dbnd_in_if.sink     in_i,
  dbnd_out_if.source  out_o
);

  dbnd_pkg::dp_cmd_t    cmd;
  dbnd_pkg::dp_status_t status;

  dbnd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  dbnd_datapath #(
    .MaxDegree (MAX_DEGREE)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .data_byte_i   (in_i.data_byte),
    .list_start_i  (in_i.list_start),
    .degree_i      (in_i.degree),
    .neighbor_id_o (out_o.neighbor_id),
    .last_o        (out_o.last)
  );

endmodule

// ----- hw/rtl/dbnd_datapath.sv -----
// decoder datapath: list state, bit buffer, delta adder and result register
module dbnd_datapath #(
  parameter int unsigned MaxDegree = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  dbnd_pkg::dp_cmd_t             cmd_i,
  output dbnd_pkg::dp_status_t          status_o,
  input  logic [dbnd_pkg::ByteW-1:0]    data_byte_i,
  input  logic                          list_start_i,
  input  logic [dbnd_pkg::DegW-1:0]     degree_i,
  output logic [dbnd_pkg::IdW-1:0]      neighbor_id_o,
  output logic                          last_o
);

  logic                          active_q, active_d;
  logic                          first_pend_q, first_pend_d;
  logic [dbnd_pkg::HdrW-1:0]     hdr_cnt_q, hdr_cnt_d;
  logic [dbnd_pkg::WidthW-1:0]   width_q, width_d;
  logic [dbnd_pkg::DegW-1:0]     remaining_q, remaining_d;
  logic [dbnd_pkg::BitsW-1:0]    bits_q, bits_d;
  logic [dbnd_pkg::BufW-1:0]     buf_q, buf_d;
  logic [dbnd_pkg::IdW-1:0]      prev_q, prev_d;
  logic [dbnd_pkg::IdW-1:0]      out_id_q, out_id_d;
  logic                          out_last_q, out_last_d;

  logic [dbnd_pkg::IdW-1:0]      delta_mask;
  logic [dbnd_pkg::IdW-1:0]      delta;
  logic [dbnd_pkg::IdW-1:0]      sum;
  logic [dbnd_pkg::IdW-1:0]      next_id;
  logic [dbnd_pkg::DegW-1:0]     deg_sat;
  logic [dbnd_pkg::WidthW-1:0]   width_sat;
  logic                          hdr_done;
  logic                          width_zero;
  logic                          final_emit;

  assign hdr_done   = hdr_cnt_q[dbnd_pkg::HdrW-1];
  assign width_zero = (width_q == '0);
  assign delta_mask = ~({dbnd_pkg::IdW{1'b1}} << width_q);
  assign delta      = buf_q[dbnd_pkg::IdW-1:0] & delta_mask;
  assign sum        = prev_q + delta;
  assign next_id    = (first_pend_q || width_zero) ? prev_q : sum;
  assign final_emit = (remaining_q == dbnd_pkg::DegW'(1));
  assign deg_sat    = (degree_i > dbnd_pkg::DegW'(MaxDegree)) ?
                      dbnd_pkg::DegW'(MaxDegree) : degree_i;
  assign width_sat  = (data_byte_i > dbnd_pkg::ByteW'(dbnd_pkg::MaxDeltaWidth)) ?
                      dbnd_pkg::MaxDeltaWidth : data_byte_i[dbnd_pkg::WidthW-1:0];

  assign status_o.can_emit = first_pend_q ||
                             (active_q && hdr_done &&
                              (width_zero || (bits_q >= width_q)));

  always_comb begin
    active_d     = active_q;
    first_pend_d = first_pend_q;
    hdr_cnt_d    = hdr_cnt_q;
    width_d      = width_q;
    remaining_d  = remaining_q;
    bits_d       = bits_q;
    buf_d        = buf_q;
    prev_d       = prev_q;
    out_id_d     = out_id_q;
    out_last_d   = out_last_q;
    if (cmd_i.take) begin
      if (list_start_i) begin
        width_d      = width_sat;
        hdr_cnt_d    = '0;
        prev_d       = '0;
        buf_d        = '0;
        bits_d       = '0;
        remaining_d  = deg_sat;
        active_d     = (deg_sat != '0);
        first_pend_d = 1'b0;
      end else if (active_q) begin
        if (!hdr_done) begin
          prev_d    = prev_q | (dbnd_pkg::IdW'(data_byte_i) << {hdr_cnt_q[1:0], 3'b000});
          hdr_cnt_d = hdr_cnt_q + 1'b1;
          if (hdr_cnt_q == dbnd_pkg::LastHdrByte) begin
            first_pend_d = 1'b1;
          end
        end else begin
          buf_d  = buf_q | (dbnd_pkg::BufW'(data_byte_i) << bits_q);
          bits_d = bits_q + dbnd_pkg::BitsPerByte;
        end
      end
    end else if (cmd_i.emit) begin
      out_id_d     = next_id;
      out_last_d   = final_emit;
      prev_d       = next_id;
      first_pend_d = 1'b0;
      remaining_d  = remaining_q - 1'b1;
      if (!first_pend_q && !width_zero) begin
        buf_d  = buf_q >> width_q;
        bits_d = bits_q - width_q;
      end
      if (final_emit) begin
        active_d = 1'b0;
        buf_d    = '0;
        bits_d   = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q     <= 1'b0;
      first_pend_q <= 1'b0;
      hdr_cnt_q    <= '0;
      width_q      <= '0;
      remaining_q  <= '0;
      bits_q       <= '0;
    end else begin
      active_q     <= active_d;
      first_pend_q <= first_pend_d;
      hdr_cnt_q    <= hdr_cnt_d;
      width_q      <= width_d;
      remaining_q  <= remaining_d;
      bits_q       <= bits_d;
    end
  end

  always_ff @(posedge clk_i) begin
    buf_q      <= buf_d;
    prev_q     <= prev_d;
    out_id_q   <= out_id_d;
    out_last_q <= out_last_d;
  end

  assign neighbor_id_o = out_id_q;
  assign last_o        = out_last_q;

endmodule

// ----- hw/rtl/dbnd_ctrl.sv -----
// decoder controller: takes one byte, then drains the ids it yields
module dbnd_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  input  dbnd_pkg::dp_status_t   status_i,
  output dbnd_pkg::dp_cmd_t      cmd_o
);

  typedef enum logic [1:0] {
    ST_IN,
    ST_EVAL,
    ST_OUT
  } state_e;

  state_e state_q;
  logic   out_valid_q;

  assign in_ready_o  = (state_q == ST_IN);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o.take = (state_q == ST_IN) && in_valid_i;
    cmd_o.emit = (state_q == ST_EVAL) && status_i.can_emit;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IN;
      out_valid_q <= 1'b0;
    end else begin
      case (state_q)
        ST_IN: begin
          if (in_valid_i) begin
            state_q <= ST_EVAL;
          end
        end
        ST_EVAL: begin
          if (status_i.can_emit) begin
            state_q     <= ST_OUT;
            out_valid_q <= 1'b1;
          end else begin
            state_q <= ST_IN;
          end
        end
        ST_OUT: begin
          if (out_ready_i) begin
            state_q     <= ST_EVAL;
            out_valid_q <= 1'b0;
          end
        end
        default: begin
          state_q     <= ST_IN;
          out_valid_q <= 1'b0;
        end
      endcase
    end
  end

endmodule

// ----- hw/rtl/dbnd_checker.sv -----
// port-level checks for the neighbor decoder and their binding
module dbnd_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_ready_i,
  input logic                         out_valid_i,
  input logic                         out_ready_i,
  input logic [dbnd_pkg::IdW-1:0]     neighbor_id_i,
  input logic                         last_i
);

  // one byte or one id in work at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_i && out_valid_i))
    else $error("input ready while a result is pending");

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=>
      (out_valid_i && $stable(neighbor_id_i) && $stable(last_i)))
    else $error("stalled result changed");

  // an accepted byte is examined before any result appears
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) |=> (!out_valid_i && !in_ready_i))
    else $error("no evaluation cycle after input transfer");

  // after a result transfer the block looks for the next id
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && out_ready_i) |=> (!out_valid_i && !in_ready_i))
    else $error("no evaluation cycle after output transfer");

endmodule

bind delta_bitpack_neighbor_decoder dbnd_checker u_dbnd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .neighbor_id_i (out_o.neighbor_id),
  .last_i        (out_o.last)
);
